[rtl/tafd_pkg.sv]
//------------------------------------------------------------------------------
// tafd_pkg
// shared types, constants and helpers of the tile attribute fetch and decode
//------------------------------------------------------------------------------
`default_nettype none

package tafd_pkg;

  localparam int SCREEN_WIDTH    = 280;
  localparam int TILE_COUNT      = 8192;
  localparam int SPLIT_X         = 40;
  localparam int WRAP_STEP       = 256;
  localparam int COLSCROLL_DEPTH = 64;
  localparam int CFG_IDX_W       = 3;

  typedef enum logic [1:0] {
    OP_TILE      = 2'd0,
    OP_SCROLL_WR = 2'd1,
    OP_EMPTY_WR  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCROLL_X   = 3'd0,
    REG_CTRL_ONE   = 3'd1,
    REG_SCROLL_Y   = 3'd2,
    REG_CTRL_THREE = 3'd3,
    REG_CTRL_FOUR  = 3'd4,
    REG_CTRL_FIVE  = 3'd5,
    REG_CTRL_SIX   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] scroll_x;
    logic [7:0] ctrl_one;
    logic [7:0] scroll_y;
    logic [7:0] ctrl_three;
    logic [7:0] ctrl_four;
    logic [7:0] ctrl_five;
    logic [7:0] ctrl_six;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic [1:0]         op;
    logic [12:0]        table_index;
    logic [7:0]         table_data;
    logic [12:0]        code;
    logic [6:0]         color;
    logic               opaque;
    logic signed [10:0] min_x;
    logic signed [10:0] max_x;
    logic signed [10:0] sx_scroll;
    logic [7:0]         sx;
    logic [7:0]         row8;
    logic [7:0]         ysub;
    logic               cs_use;
    logic               drop;
  } s1_t;

  typedef struct packed {
    logic               valid;
    logic [12:0]        code;
    logic [6:0]         color;
    logic               opaque;
    logic [8:0]         clip_min;
    logic [8:0]         clip_max;
    logic signed [10:0] pos0;
    logic signed [10:0] pos_y;
    logic [1:0]         copies;
    logic               empty;
  } s2_t;

  function automatic logic [8:0] clip9(input logic signed [10:0] v);
    logic [8:0] r;
    if (v < 11'sd0) r = 9'd0;
    else if (v > 11'sd511) r = 9'd511;
    else r = v[8:0];
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/tafd_if.sv]
//------------------------------------------------------------------------------
// tafd channel interfaces
// item, result and configuration write channels with valid/ready
//------------------------------------------------------------------------------
`default_nettype none

interface tafd_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic        layer;
  logic        pass;
  logic        category;
  logic [9:0]  tile_index;
  logic [7:0]  attr_byte;
  logic [7:0]  code_byte;
  logic [12:0] table_index;
  logic [7:0]  table_data;
  modport source (output valid, op, layer, pass, category, tile_index, attr_byte,
                  code_byte, table_index, table_data, input ready);
  modport sink (input valid, op, layer, pass, category, tile_index, attr_byte,
                code_byte, table_index, table_data, output ready);
endinterface

interface tafd_result_if;
  logic               valid;
  logic               ready;
  logic [12:0]        tile_code;
  logic [6:0]         color;
  logic signed [10:0] pos_x;
  logic signed [10:0] pos_y;
  logic               opaque;
  logic [8:0]         clip_min;
  logic [8:0]         clip_max;
  logic               last;
  modport source (output valid, tile_code, color, pos_x, pos_y, opaque, clip_min,
                  clip_max, last, input ready);
  modport sink (input valid, tile_code, color, pos_x, pos_y, opaque, clip_min,
                clip_max, last, output ready);
endinterface

interface tafd_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/tafd_decode.sv]
//------------------------------------------------------------------------------
// tafd_decode
// first stage: tile code, colour, clip bounds, scroll terms, column scroll read
//------------------------------------------------------------------------------
`default_nettype none

module tafd_decode (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         en,
  input  wire tafd_pkg::cfg_t cfg,
  tafd_item_if.sink         item,
  output tafd_pkg::s1_t     s1,
  output logic [7:0]        col_scroll
);
  import tafd_pkg::*;

  localparam logic signed [10:0] SW11    = 11'(SCREEN_WIDTH);
  localparam logic signed [10:0] SPLIT11 = 11'(SPLIT_X);

  logic [7:0] cs_mem [COLSCROLL_DEPTH];
  logic [COLSCROLL_DEPTH-1:0] cs_vld;
  logic [5:0] cs_raddr;
  logic       cs_wr;
  s1_t        s1_next;

  logic               title, inv, split, yon;
  logic signed [10:0] sxv;
  logic [3:0]         bm;
  logic [4:0]         bank, hi;
  logic [4:0]         col;

  assign item.ready = en;
  assign col        = item.tile_index[4:0];
  assign cs_raddr   = {1'b0, col - 5'd2};
  assign cs_wr      = en && item.valid && item.op == OP_SCROLL_WR
                      && item.table_index[12:6] == 7'd0;

  always_comb begin
    title = cfg.ctrl_three[5];
    inv   = ~cfg.ctrl_one[0];
    sxv   = {3'b000, cfg.scroll_x};
    split = title && cfg.scroll_x < 8'(SPLIT_X);
    yon   = 1'b1;

    s1_next             = '0;
    s1_next.valid       = item.valid;
    s1_next.op          = item.op;
    s1_next.table_index = item.table_index;
    s1_next.table_data  = item.table_data;
    s1_next.min_x       = 11'sd0;
    s1_next.max_x       = SW11;
    s1_next.sx_scroll   = sxv;
    s1_next.opaque      = 1'b0;

    if (title) begin
      if (item.layer == inv) begin
        s1_next.min_x = SW11 - sxv + 11'sd8;
      end else begin
        if (split) s1_next.min_x = SPLIT11 - sxv;
        s1_next.max_x = SW11 - sxv + 11'sd8;
      end
      s1_next.sx_scroll = sxv - SPLIT11;
    end else if (!item.layer) begin
      s1_next.min_x     = SPLIT11;
      s1_next.max_x     = 11'sd280;
      s1_next.sx_scroll = sxv - SPLIT11;
      s1_next.opaque    = 1'b1;
    end else begin
      yon               = 1'b0;
      s1_next.sx_scroll = 11'sd0;
      s1_next.max_x     = SPLIT11;
      s1_next.opaque    = 1'b1;
    end

    if (item.pass && item.layer == inv) begin
      s1_next.min_x = 11'sd0;
      s1_next.max_x = SPLIT11 - sxv - 11'sd8;
    end

    s1_next.drop = (item.pass && !split)
                   || (!item.layer && item.attr_byte[6] != item.category);

    bank = {item.attr_byte[3'd3 + 3'(cfg.ctrl_five[7:6])],
            item.attr_byte[3'd3 + 3'(cfg.ctrl_five[5:4])],
            item.attr_byte[3'd3 + 3'(cfg.ctrl_five[3:2])],
            item.attr_byte[3'd3 + 3'(cfg.ctrl_five[1:0])],
            item.attr_byte[7]};
    bm   = cfg.ctrl_four[7:4];
    hi   = (bank & ~{bm, 1'b0}) | {cfg.ctrl_four[3:0] & bm, 1'b0};

    s1_next.code   = {hi, item.code_byte};
    s1_next.color  = {cfg.ctrl_six[5:4], 1'b1, 1'b0, item.attr_byte[2:0]};
    s1_next.sx     = {col, 3'b000};
    s1_next.row8   = {item.tile_index[9:5], 3'b000};
    s1_next.ysub   = yon ? cfg.scroll_y : 8'd0;
    s1_next.cs_use = yon && cfg.ctrl_one[2:1] == 2'b11 && col >= 5'd2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      cs_vld   <= '0;
    end else if (en) begin
      s1 <= s1_next;
      if (cs_wr) cs_vld[item.table_index[5:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cs_wr) cs_mem[item.table_index[5:0]] <= item.table_data;
    if (en) col_scroll <= cs_vld[cs_raddr] ? cs_mem[cs_raddr] : 8'd0;
  end

endmodule

`default_nettype wire

[rtl/tafd_place.sv]
//------------------------------------------------------------------------------
// tafd_place
// second stage: scrolled y with wrap, copy count, clip saturation, empty map
//------------------------------------------------------------------------------
`default_nettype none

module tafd_place #(
  parameter int TILE_COUNT = tafd_pkg::TILE_COUNT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire tafd_pkg::s1_t s1,
  input  wire logic [7:0]    col_scroll,
  output tafd_pkg::s2_t      s2
);
  import tafd_pkg::*;

  localparam int AW = $clog2(TILE_COUNT);
  localparam logic [13:0] TC14 = 14'(TILE_COUNT);
  localparam logic signed [10:0] SW11 = 11'(SCREEN_WIDTH);

  logic emap [TILE_COUNT];
  logic empty_q, hit_q;
  logic em_wr;
  s2_t  s2_r, s2_next;
  logic signed [10:0] sy;
  logic [7:0] cs_eff;

  assign em_wr = en && s1.valid && s1.op == OP_EMPTY_WR && {1'b0, s1.table_index} < TC14;

  always_comb begin
    cs_eff = s1.cs_use ? col_scroll : 8'd0;
    sy = {3'b000, s1.row8} - {3'b000, cs_eff} - {3'b000, s1.ysub} - 11'd16;
    if (sy < -11'sd7) sy = sy + 11'sd256;

    s2_next          = '0;
    s2_next.valid    = s1.valid && s1.op == OP_TILE && !s1.drop;
    s2_next.code     = s1.code;
    s2_next.color    = s1.color;
    s2_next.opaque   = s1.opaque;
    s2_next.clip_min = clip9(s1.min_x);
    s2_next.clip_max = clip9(s1.max_x);
    s2_next.pos0     = {3'b000, s1.sx} - s1.sx_scroll + 11'sd256;
    s2_next.pos_y    = sy;
    s2_next.copies   = 2'd1 + 2'(s1.sx_scroll < SW11)
                       + 2'((s1.sx_scroll + 11'sd256) < SW11);
  end

  always_ff @(posedge clk) begin
    if (rst) s2_r.valid <= 1'b0;
    else if (en) s2_r <= s2_next;
  end

  always_ff @(posedge clk) begin
    if (em_wr) emap[s1.table_index[AW-1:0]] <= s1.table_data[0];
    if (en) begin
      empty_q <= emap[s1.code[AW-1:0]];
      hit_q   <= {1'b0, s1.code} < TC14;
    end
  end

  always_comb begin
    s2       = s2_r;
    s2.empty = empty_q && hit_q;
  end

endmodule

`default_nettype wire

[rtl/tafd_emit.sv]
//------------------------------------------------------------------------------
// tafd_emit
// third stage: skip test and wrap copy output register, one beat per copy
//------------------------------------------------------------------------------
`default_nettype none

module tafd_emit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tafd_pkg::s2_t s2,
  output logic               en,
  tafd_result_if.source      result
);
  import tafd_pkg::*;

  logic [1:0] cnt;
  logic       fire, load;

  assign fire = result.valid && result.ready;
  assign load = s2.valid && !(s2.empty && !s2.opaque);
  assign en   = cnt == 2'd0 || (fire && cnt == 2'd1);

  assign result.valid = cnt != 2'd0;
  assign result.last  = cnt == 2'd1;

  always_ff @(posedge clk) begin
    if (rst) cnt <= 2'd0;
    else if (en) cnt <= load ? s2.copies : 2'd0;
    else if (fire) cnt <= cnt - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (en && load) begin
      result.tile_code <= s2.code;
      result.color     <= s2.color;
      result.pos_x     <= s2.pos0;
      result.pos_y     <= s2.pos_y;
      result.opaque    <= s2.opaque;
      result.clip_min  <= s2.clip_min;
      result.clip_max  <= s2.clip_max;
    end else if (fire) begin
      result.pos_x <= result.pos_x - 11'sd256;
    end
  end

`ifndef SYNTH
  a_hold_pipe: assert property (@(posedge clk) disable iff (rst) cnt > 2'd1 |-> !en)
    else $error("pipeline advanced with copies pending");
  a_step_x: assert property (@(posedge clk) disable iff (rst)
      fire && !result.last |=> result.pos_x == $past(result.pos_x) - 11'sd256)
    else $error("wrap copy x step wrong");
  a_drain: assert property (@(posedge clk) disable iff (rst)
      fire && result.last && !load |=> !result.valid)
    else $error("result beat after final copy");
`endif

endmodule

`default_nettype wire

[rtl/tile_attribute_fetch_decode_top.sv]
//------------------------------------------------------------------------------
// tile_attribute_fetch_decode_top
// tilemap cell bank, colour, scroll and wrap copy decode
//
// channel | dir | beat
// item    | in  | one tile cell or one table write
// result  | out | one wrap copy of a cell, last on the final copy
// cfg     | in  | one control register write, always ready
//
// three register stages (decode, place, emit); a cell passes decode and place,
// then leaves one copy per cycle while result is ready, two or three copies.
// a new item enters in any cycle in which the emit register is empty or its
// final copy is taken.
// rst is synchronous; column scroll entries read zero until written.
// a stalled result holds the whole pipeline; nothing is lost or repeated.
//------------------------------------------------------------------------------
`default_nettype none

module tile_attribute_fetch_decode_top #(
  parameter int TILE_COUNT = tafd_pkg::TILE_COUNT
) (
  input  wire logic     clk,
  input  wire logic     rst,
  tafd_item_if.sink     item,
  tafd_result_if.source result,
  tafd_cfg_if.sink      cfg
);
  import tafd_pkg::*;

  cfg_t       regs;
  s1_t        s1;
  s2_t        s2;
  logic [7:0] col_scroll;
  logic       en;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SCROLL_X:   regs.scroll_x   <= cfg.data;
        REG_CTRL_ONE:   regs.ctrl_one   <= cfg.data;
        REG_SCROLL_Y:   regs.scroll_y   <= cfg.data;
        REG_CTRL_THREE: regs.ctrl_three <= cfg.data;
        REG_CTRL_FOUR:  regs.ctrl_four  <= cfg.data;
        REG_CTRL_FIVE:  regs.ctrl_five  <= cfg.data;
        REG_CTRL_SIX:   regs.ctrl_six   <= cfg.data;
        default: ;
      endcase
    end
  end

  tafd_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .cfg        (regs),
    .item       (item),
    .s1         (s1),
    .col_scroll (col_scroll)
  );

  tafd_place #(
    .TILE_COUNT (TILE_COUNT)
  ) u_place (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .s1         (s1),
    .col_scroll (col_scroll),
    .s2         (s2)
  );

  tafd_emit u_emit (
    .clk    (clk),
    .rst    (rst),
    .s2     (s2),
    .en     (en),
    .result (result)
  );

endmodule

`default_nettype wire

[verif/tile_attribute_fetch_decode_checker.sv]
//------------------------------------------------------------------------------
// tile_attribute_fetch_decode_checker
// watches the item, configuration and result channels of the tile attribute
// decode, keeps its own register, column scroll and empty-tile copies, works
// out the wrap copies of every accepted cell and compares each result beat
// with the oldest copy still due
//------------------------------------------------------------------------------
module tile_attribute_fetch_decode_checker (
  input  wire logic clk,
  input  wire logic rst,
  tafd_item_if      item,
  tafd_result_if    result,
  tafd_cfg_if       cfg,
  output int        errors,
  output int        copies_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import tafd_pkg::*;

  typedef struct packed {
    logic [12:0]        tile_code;
    logic [6:0]         color;
    logic signed [10:0] pos_x;
    logic signed [10:0] pos_y;
    logic               opaque;
    logic [8:0]         clip_min;
    logic [8:0]         clip_max;
    logic               last;
  } cell_copy_t;

  cfg_t       regs;
  logic [7:0] col_scroll [COLSCROLL_DEPTH];
  bit         empty_map [TILE_COUNT];
  cell_copy_t copies_due [$];
  int         fails = 0;
  int         shown = 0;

  initial begin
    errors = 0;
    copies_pending = 0;
  end

  function automatic logic [8:0] saturate_clip(input int v);
    if (v < 0) return 9'd0;
    if (v > 511) return 9'd511;
    return v[8:0];
  endfunction

  function automatic void predict_cell(input logic layer, input logic pass_no,
                                       input logic category, input logic [9:0] idx,
                                       input logic [7:0] attr, input logic [7:0] codeb);
    int         sxr, syr, sx_scroll, min_x, max_x, sx, sy, xw, pos, copies;
    int         a, col, sh0, sh1, sh2, sel3, b4, bank, bmask, hi, codev, colv;
    bit         yscroll_on, opaque, split, inv;
    cell_copy_t c;
    sxr = int'(regs.scroll_x);
    syr = int'(regs.scroll_y);
    sx_scroll = sxr;
    yscroll_on = 1'b1;
    opaque = 1'b0;
    min_x = 0;
    max_x = SCREEN_WIDTH;
    split = 1'b0;
    inv = ~regs.ctrl_one[0];

    if (regs.ctrl_three[5]) begin
      split = sxr < SPLIT_X;
      if (layer == inv) min_x = SCREEN_WIDTH - sxr + 8;
      if (layer != inv) begin
        if (split) min_x = SPLIT_X - sxr;
        max_x = SCREEN_WIDTH - sxr + 8;
      end
      sx_scroll = sxr - SPLIT_X;
    end else if (!layer) begin
      min_x = SPLIT_X;
      max_x = 280;
      sx_scroll = sxr - SPLIT_X;
      opaque = 1'b1;
    end else begin
      yscroll_on = 1'b0;
      sx_scroll = 0;
      max_x = SPLIT_X;
      opaque = 1'b1;
    end

    if (pass_no) begin
      if (!split) return;
      if (layer == inv) begin
        min_x = 0;
        max_x = SPLIT_X - sxr - 8;
        if (max_x < 0) max_x = 0;
      end
    end

    if (!layer && attr[6] != category) return;

    col = int'(idx[4:0]);
    sx = col * 8;
    sy = int'(idx[9:5]) * 8;
    if (yscroll_on) begin
      if (regs.ctrl_one[2:1] == 2'b11 && col >= 2) sy -= int'(col_scroll[col - 2]);
      sy -= syr;
    end
    sy -= 16;
    if (sy < -7) sy += 256;

    // bank bits from the attribute byte; a zero top selector means a left shift
    a = int'(attr);
    sh0 = int'(regs.ctrl_five[1:0]) + 2;
    sh1 = int'(regs.ctrl_five[3:2]) + 1;
    sh2 = int'(regs.ctrl_five[5:4]);
    sel3 = int'(regs.ctrl_five[7:6]);
    if (sel3 == 0) b4 = (a << 1) & 16;
    else b4 = (a >> (sel3 - 1)) & 16;
    bank = ((a >> 7) & 1) | ((a >> sh0) & 2) | ((a >> sh1) & 4) | ((a >> sh2) & 8) | b4 |
           (int'(regs.ctrl_three[0]) << 5);
    bmask = int'(regs.ctrl_four[7:4]);
    hi = (bank & ~(bmask << 1)) | ((int'(regs.ctrl_four) & bmask) << 1);
    codev = (int'(codeb) + (hi << 8)) & 8191;
    colv = ((int'(regs.ctrl_six) & 48) << 1) | (a & 7) | 16;

    if (codev < TILE_COUNT && empty_map[codev] && !opaque) return;

    c.tile_code = codev[12:0];
    c.color = colv[6:0];
    c.pos_y = sy[10:0];
    c.opaque = opaque;
    c.clip_min = saturate_clip(min_x);
    c.clip_max = saturate_clip(max_x);
    copies = 0;
    for (xw = sx_scroll - WRAP_STEP; xw < SCREEN_WIDTH && copies < 3; xw += WRAP_STEP) begin
      pos = sx - xw;
      c.pos_x = pos[10:0];
      c.last = !(xw + WRAP_STEP < SCREEN_WIDTH && copies < 2);
      copies_due.push_back(c);
      copies++;
    end
  endfunction

  always @(posedge clk) begin
    cell_copy_t want, got;
    if (rst) begin
      regs = '0;
      foreach (col_scroll[i]) col_scroll[i] = 8'd0;
      copies_due.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_SCROLL_X:   regs.scroll_x = cfg.data;
          REG_CTRL_ONE:   regs.ctrl_one = cfg.data;
          REG_SCROLL_Y:   regs.scroll_y = cfg.data;
          REG_CTRL_THREE: regs.ctrl_three = cfg.data;
          REG_CTRL_FOUR:  regs.ctrl_four = cfg.data;
          REG_CTRL_FIVE:  regs.ctrl_five = cfg.data;
          REG_CTRL_SIX:   regs.ctrl_six = cfg.data;
          default: ;
        endcase
      end

      if (item.valid && item.ready) begin
        case (item.op)
          OP_TILE: begin
            predict_cell(item.layer, item.pass, item.category, item.tile_index,
                         item.attr_byte, item.code_byte);
          end
          OP_SCROLL_WR: begin
            if (item.table_index < COLSCROLL_DEPTH)
              col_scroll[item.table_index[5:0]] = item.table_data;
          end
          OP_EMPTY_WR: begin
            if (item.table_index < TILE_COUNT) empty_map[item.table_index] = item.table_data[0];
          end
          default: ;
        endcase
      end

      if (result.valid && result.ready) begin
        got.tile_code = result.tile_code;
        got.color = result.color;
        got.pos_x = result.pos_x;
        got.pos_y = result.pos_y;
        got.opaque = result.opaque;
        got.clip_min = result.clip_min;
        got.clip_max = result.clip_max;
        got.last = result.last;
        if (copies_due.size() == 0) begin
          fails++;
          if (shown < 10) begin
            $display("unexpected result beat: code=%h x=%0d y=%0d last=%b",
                     got.tile_code, got.pos_x, got.pos_y, got.last);
            shown++;
          end
        end else begin
          want = copies_due.pop_front();
          if (got !== want) begin
            fails++;
            if (shown < 10) begin
              $display("mismatch expected: code=%h color=%h x=%0d y=%0d opaque=%b clip=%0d:%0d last=%b",
                       want.tile_code, want.color, want.pos_x, want.pos_y, want.opaque,
                       want.clip_min, want.clip_max, want.last);
              $display("         actual:   code=%h color=%h x=%0d y=%0d opaque=%b clip=%0d:%0d last=%b",
                       got.tile_code, got.color, got.pos_x, got.pos_y, got.opaque,
                       got.clip_min, got.clip_max, got.last);
              shown++;
            end
          end
        end
      end
    end
    copies_pending <= copies_due.size();
    errors <= fails;
  end

endmodule

[verif/tile_attribute_fetch_decode_top_tb.sv]
//------------------------------------------------------------------------------
// tile_attribute_fetch_decode_top_tb
// loads the empty-tile entry of every cell ahead of the cell that reads it,
// then drives directed and random tile cells and table beats through several
// register settings with random idle bursts on both channels; the checker
// beside the block does the comparing
//------------------------------------------------------------------------------
module tile_attribute_fetch_decode_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tafd_pkg::*;

  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          DRAIN_CYCLES = 12;
  localparam int          RANDOM_CELLS = 120;
  localparam int          PHASES       = 6;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam logic [12:0] EMPTY_PROBE  = 13'h0a05;
  localparam logic [12:0] CLEAR_PROBE  = 13'h0a06;

  typedef struct packed {
    logic [1:0]  op;
    logic        layer;
    logic        pass;
    logic        category;
    logic [9:0]  tile_index;
    logic [7:0]  attr_byte;
    logic [7:0]  code_byte;
    logic [12:0] table_index;
    logic [7:0]  table_data;
  } beat_t;

  logic clk;
  logic rst;
  int   errors;
  int   copies_pending;
  int   cycles = 0;
  bit   calm = 1'b0;
  cfg_t regs_now = '0;
  bit   written [TILE_COUNT];

  tafd_item_if   item_if();
  tafd_result_if res_if();
  tafd_cfg_if    cfg_if();

  tile_attribute_fetch_decode_top dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (res_if),
    .cfg    (cfg_if)
  );

  tile_attribute_fetch_decode_checker chk (
    .clk            (clk),
    .rst            (rst),
    .item           (item_if),
    .result         (res_if),
    .cfg            (cfg_if),
    .errors         (errors),
    .copies_pending (copies_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    res_if.ready = 1'b0;
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        res_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  function automatic beat_t random_beat();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(beat_t)-1:0];
  endfunction

  function automatic cfg_t random_regs();
    cfg_t v;
    v.scroll_x   = $urandom_range(0, 1) ? 8'($urandom_range(0, SPLIT_X - 1))
                                        : 8'($urandom_range(0, 255));
    v.ctrl_one   = 8'($urandom_range(0, 255));
    v.scroll_y   = 8'($urandom_range(0, 255));
    v.ctrl_three = 8'($urandom_range(0, 255));
    v.ctrl_four  = 8'($urandom_range(0, 255));
    v.ctrl_five  = 8'($urandom_range(0, 255));
    v.ctrl_six   = 8'($urandom_range(0, 255));
    return v;
  endfunction

  // tile code that a cell reads from the empty-tile map
  function automatic logic [12:0] cell_code(input cfg_t v, input logic [7:0] attr,
                                            input logic [7:0] codeb);
    int a, sel3, b4, bank, bmask, hi;
    a = int'(attr);
    sel3 = int'(v.ctrl_five[7:6]);
    if (sel3 == 0) b4 = (a << 1) & 16;
    else b4 = (a >> (sel3 - 1)) & 16;
    bank = ((a >> 7) & 1) | ((a >> (int'(v.ctrl_five[1:0]) + 2)) & 2) |
           ((a >> (int'(v.ctrl_five[3:2]) + 1)) & 4) |
           ((a >> int'(v.ctrl_five[5:4])) & 8) | b4;
    bmask = int'(v.ctrl_four[7:4]);
    hi = (bank & ~(bmask << 1)) | ((int'(v.ctrl_four) & bmask) << 1);
    return {hi[4:0], codeb};
  endfunction

  task automatic send_beat(input beat_t b);
    item_if.valid       <= 1'b1;
    item_if.op          <= b.op;
    item_if.layer       <= b.layer;
    item_if.pass        <= b.pass;
    item_if.category    <= b.category;
    item_if.tile_index  <= b.tile_index;
    item_if.attr_byte   <= b.attr_byte;
    item_if.code_byte   <= b.code_byte;
    item_if.table_index <= b.table_index;
    item_if.table_data  <= b.table_data;
    do @(posedge clk); while (!item_if.ready);
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic send_table(input logic [1:0] op, input logic [12:0] tidx,
                            input logic [7:0] tdata);
    beat_t b;
    sender_gap();
    b = random_beat();
    b.op = op;
    b.table_index = tidx;
    b.table_data = tdata;
    send_beat(b);
    if (op == OP_EMPTY_WR) written[tidx] = 1'b1;
  endtask

  task automatic send_cell(input logic layer, input logic pass_no, input logic cat,
                           input logic [9:0] idx, input logic [7:0] attr,
                           input logic [7:0] codeb);
    beat_t       b;
    logic [12:0] code;
    code = cell_code(regs_now, attr, codeb);
    if (!written[code])
      send_table(OP_EMPTY_WR, code, {7'($urandom), $urandom_range(0, 5) == 0});
    sender_gap();
    b = random_beat();
    b.op = OP_TILE;
    b.layer = layer;
    b.pass = pass_no;
    b.category = cat;
    b.tile_index = idx;
    b.attr_byte = attr;
    b.code_byte = codeb;
    send_beat(b);
  endtask

  // wait for every due copy, then let table writes leave the pipeline
  task automatic settle();
    item_if.valid <= 1'b0;
    @(posedge clk);
    while (copies_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input cfg_t v);
    cfg_reg_t r;
    settle();
    r = r.first();
    repeat (r.num()) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= r;
      case (r)
        REG_SCROLL_X:   cfg_if.data <= v.scroll_x;
        REG_CTRL_ONE:   cfg_if.data <= v.ctrl_one;
        REG_SCROLL_Y:   cfg_if.data <= v.scroll_y;
        REG_CTRL_THREE: cfg_if.data <= v.ctrl_three;
        REG_CTRL_FOUR:  cfg_if.data <= v.ctrl_four;
        REG_CTRL_FIVE:  cfg_if.data <= v.ctrl_five;
        default:        cfg_if.data <= v.ctrl_six;
      endcase
      do @(posedge clk); while (!cfg_if.ready);
      r = r.next();
    end
    cfg_if.valid <= 1'b0;
    regs_now = v;
  endtask

  initial begin
    cfg_t       setting;
    logic [7:0] attr;
    logic [9:0] idx;
    bit         split_on;
    int         pick;

    item_if.valid = 1'b0;
    item_if.op = OP_TILE;
    item_if.layer = 1'b0;
    item_if.pass = 1'b0;
    item_if.category = 1'b0;
    item_if.tile_index = '0;
    item_if.attr_byte = '0;
    item_if.code_byte = '0;
    item_if.table_index = '0;
    item_if.table_data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_SCROLL_X;
    cfg_if.data = '0;
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    setting = '0;
    write_regs(setting);

    // probe entries with known empty flags
    send_table(OP_EMPTY_WR, EMPTY_PROBE, 8'h01);
    send_table(OP_EMPTY_WR, CLEAR_PROBE, 8'h00);

    // out of range and unused table beats
    send_table(OP_SCROLL_WR, 13'd64, 8'hff);
    send_table(OP_SCROLL_WR, 13'h1fff, 8'h00);
    send_table(OP_UNUSED, 13'h1555, 8'haa);

    // game mode, bank override pointing at the probe codes
    setting = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hf5, 8'h00, 8'h30};
    write_regs(setting);
    send_cell(1'b0, 1'b0, 1'b0, 10'h000, 8'h00, EMPTY_PROBE[7:0]);
    send_cell(1'b0, 1'b0, 1'b1, 10'h3ff, 8'h40, CLEAR_PROBE[7:0]);
    send_cell(1'b0, 1'b0, 1'b0, 10'h021, 8'h40, 8'h12);
    send_cell(1'b1, 1'b0, 1'b0, 10'h3ff, 8'hff, 8'hff);
    send_cell(1'b1, 1'b1, 1'b0, 10'h010, 8'h07, 8'h00);
    send_cell(1'b0, 1'b1, 1'b0, 10'h020, 8'h00, 8'h06);

    // title mode with split, layer swap and column scroll
    setting = '{8'h00, 8'h07, 8'hff, 8'h20, 8'hf5, 8'h00, 8'h10};
    write_regs(setting);
    send_table(OP_SCROLL_WR, 13'd5, 8'hff);
    send_cell(1'b0, 1'b0, 1'b0, 10'h0e7, 8'h00, EMPTY_PROBE[7:0]);
    send_cell(1'b0, 1'b0, 1'b0, 10'h0e7, 8'h00, CLEAR_PROBE[7:0]);
    send_cell(1'b0, 1'b0, 1'b0, 10'h3e2, 8'h07, CLEAR_PROBE[7:0]);
    send_cell(1'b1, 1'b0, 1'b1, 10'h01f, 8'h07, CLEAR_PROBE[7:0]);
    send_cell(1'b0, 1'b1, 1'b1, 10'h2a5, 8'h47, CLEAR_PROBE[7:0]);
    send_cell(1'b1, 1'b1, 1'b0, 10'h15a, 8'h03, CLEAR_PROBE[7:0]);

    // title mode past the split, no bank mask, left shift selector
    setting = '{8'hff, 8'h00, 8'h80, 8'h21, 8'h0f, 8'h00, 8'h00};
    write_regs(setting);
    send_cell(1'b1, 1'b1, 1'b0, 10'h100, 8'h12, 8'h34);
    send_cell(1'b0, 1'b0, 1'b1, 10'h3ff, 8'hff, 8'h00);
    send_cell(1'b1, 1'b0, 1'b0, 10'h155, 8'h55, 8'haa);

    setting = '1;
    write_regs(setting);
    send_cell(1'b0, 1'b0, 1'b1, 10'h2aa, 8'hc0, 8'h80);
    send_cell(1'b1, 1'b0, 1'b0, 10'h3ff, 8'h3f, 8'hff);
    send_cell(1'b0, 1'b0, 1'b0, 10'h000, 8'h3f, 8'h01);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1) calm = 1'b1;
      setting = random_regs();
      write_regs(setting);
      split_on = setting.ctrl_three[5] && setting.scroll_x < SPLIT_X;
      for (int k = 0; k < RANDOM_CELLS / PHASES; k++) begin
        if (ph == 2 && k == 19) settle();
        pick = $urandom_range(0, 19);
        attr = 8'($urandom_range(0, 255));
        idx = 10'($urandom_range(0, 1023));
        if (pick < 2) begin
          send_table(OP_SCROLL_WR, 13'($urandom_range(0, 71)), 8'($urandom_range(0, 255)));
        end else if (pick < 4) begin
          send_table(OP_EMPTY_WR, 13'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)));
        end else if (pick == 4) begin
          send_table(OP_UNUSED, 13'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)));
        end else begin
          send_cell(1'($urandom_range(0, 1)),
                    split_on ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 7) == 0),
                    ($urandom_range(0, 4) != 0) ? attr[6] : ~attr[6],
                    idx, attr, 8'($urandom_range(0, 255)));
        end
      end
    end

    settle();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
